// ----- rtl/rwrb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rwrb_pkg
// Shared types and constants of the receive window reorder buffer.
// ----------------------------------------------------------------------------
package rwrb_pkg;

  localparam int SEQ_W      = 32;
  localparam int SIZE_W     = 9;
  localparam int PCT_W      = 7;
  localparam int SLOT_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

  // Register addresses of the configuration port.
  localparam logic [0:0] REG_DROP_PERCENT = 1'b0;

  // Kind of a result word.
  typedef enum logic [2:0] {
    KIND_ACK    = 3'd0,
    KIND_DROP   = 3'd1,
    KIND_REJECT = 3'd2,
    KIND_WRITE  = 3'd3,
    KIND_DONE   = 3'd4
  } kind_t;

  // Work handed from the classifier to the result sequencer.
  typedef struct packed {
    kind_t             kind;
    logic [SEQ_W-1:0]  seq;
    logic              channel;
    logic              last;
    logic              flush;
  } job_t;

  // Contents of one buffer slot.
  typedef struct packed {
    logic [SEQ_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
  } slot_t;

endpackage
`default_nettype wire

// ----- rtl/receive_window_reorder_buffer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// receive_window_reorder_buffer_unit
// Selective-repeat receive window over byte-offset sequence numbers with a
// reorder buffer of SLOTS slots, each SLOT_BYTES bytes wide.
// ----------------------------------------------------------------------------
//
//  Port group | Direction | Word contents (lowest bit first)
//  -----------+-----------+---------------------------------------------------
//  in_*       | input     | tdata: seq_no, payload_size, channel, rand_value;
//             |           | tuser: mode; tlast: is_last
//  out_*      | output    | tdata: out_seq, out_size, out_channel, out_last,
//             |           | slot_index; tuser: kind; tlast: end_of_run
//  cfg_*      | APB       | register 0 at byte address 0: drop_percent
//
// The classifier handles an input word through capture and window distance,
// slot number by reciprocal multiply, then decision and slot write, and
// takes no new word until the last is through. A flush then walks every
// slot in the result sequencer, passing an empty slot in the scan state and
// reading a filled one out through the load state; the next word is held
// off until that walk has finished. Reset is synchronous and active low; no
// memory clearing is needed, since slot contents are read only behind their
// fill marks. Either channel may stall freely: the two-entry job queue and
// the output register keep the classifier and the sequencer apart.
//
// The window end is always start plus SLOTS*SLOT_BYTES minus one, so only
// the window start is held.
module receive_window_reorder_buffer_unit #(
  parameter int SLOTS = 8,
  parameter int SLOT_BYTES = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input channel.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [31:0] seq_no, [40:32] payload_size, [41] channel, [48:42] rand_value.
  input  wire logic [rwrb_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] mode.
  input  wire logic                              in_tuser,
  input  wire logic                              in_tlast,
  // Result channel.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] out_seq, [40:32] out_size, [41] out_channel, [42] out_last,
  // [45:43] slot_index.
  output logic      [rwrb_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [2:0] kind.
  output logic      [2:0]                        out_tuser,
  output logic                                   out_tlast,
  // Configuration port.
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [0:0]                        cfg_paddr,
  input  wire logic [rwrb_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [rwrb_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW = $bits(rwrb_pkg::job_t) + SLOTS;

  logic [rwrb_pkg::PCT_W-1:0]  drop_pct_r;
  logic                        cfg_wr;

  logic                        f_push;
  rwrb_pkg::job_t              f_job;
  logic [SLOTS-1:0]            f_mask;
  logic                        q_full;
  logic                        q_empty;
  logic                        b_pop;
  logic [QW-1:0]               q_out;
  rwrb_pkg::job_t              b_job;
  logic [SLOTS-1:0]            b_mask;

  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  rwrb_pkg::slot_t             ram_wdata;
  logic                        ram_re;
  logic [IW-1:0]               ram_raddr;
  logic [$bits(rwrb_pkg::slot_t)-1:0] ram_rdata;

  logic                        flush_done;

  // Configuration register: written in the access phase, read back as is.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == rwrb_pkg::REG_DROP_PERCENT)
                      ? {{(rwrb_pkg::CFG_DATA_W-rwrb_pkg::PCT_W){1'b0}}, drop_pct_r}
                      : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_pct_r <= '0;
    end else if (cfg_wr && (cfg_paddr == rwrb_pkg::REG_DROP_PERCENT)) begin
      drop_pct_r <= cfg_pwdata[rwrb_pkg::PCT_W-1:0];
    end
  end

  rwrb_front #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .in_tlast     (in_tlast),
    .drop_percent (drop_pct_r),
    .q_push       (f_push),
    .q_job        (f_job),
    .q_mask       (f_mask),
    .q_full       (q_full),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .flush_done   (flush_done)
  );

  rwrb_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_job, f_mask}),
    .full      (q_full),
    .pop       (b_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  assign b_job  = q_out[QW-1:SLOTS];
  assign b_mask = q_out[SLOTS-1:0];

  // Slot store: offset and size of each filled slot.
  rwrb_ram #(
    .WIDTH ($bits(rwrb_pkg::slot_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rwrb_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (b_pop),
    .q_job      (b_job),
    .q_mask     (b_mask),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .flush_done (flush_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/rwrb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rwrb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rwrb_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/rwrb_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rwrb_queue
// Two-entry queue that decouples the classifier from the result sequencer.
// ----------------------------------------------------------------------------
module rwrb_queue #(
  parameter int WIDTH = 46
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rwrb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rwrb_front
// Accepts input words, places them against the window, fills slots and
// decides whether a flush follows; hands one job per word to the queue.
// ----------------------------------------------------------------------------
module rwrb_front #(
  parameter int SLOTS = 8,
  parameter int SLOT_BYTES = 256,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [rwrb_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                              in_tuser,
  input  wire logic                              in_tlast,
  input  wire logic [rwrb_pkg::PCT_W-1:0]        drop_percent,
  output logic                                   q_push,
  output rwrb_pkg::job_t                         q_job,
  output logic      [SLOTS-1:0]                  q_mask,
  input  wire logic                              q_full,
  output logic                                   ram_we,
  output logic      [IW-1:0]                     ram_waddr,
  output rwrb_pkg::slot_t                        ram_wdata,
  input  wire logic                              flush_done
);

  localparam int WSPAN = SLOTS * SLOT_BYTES;
  localparam int NB    = (WSPAN > 1) ? $clog2(WSPAN) : 1;
  localparam int LB    = $clog2(SLOT_BYTES);
  localparam int SH    = NB + LB;
  localparam int MW    = SH + 1;
  localparam int PW    = NB + MW;
  // Reciprocal of the slot size, rounded up; exact for offsets below 2^NB.
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + SLOT_BYTES - 1) / SLOT_BYTES);
  localparam logic [rwrb_pkg::SEQ_W-1:0] WIN_SPAN = rwrb_pkg::SEQ_W'(WSPAN);
  localparam logic [rwrb_pkg::SEQ_W-1:0] WIN_LAST = rwrb_pkg::SEQ_W'(WSPAN - 1);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_DECIDE
  } fstate_t;

  fstate_t                            state_r;
  logic                               mode_r;
  logic [rwrb_pkg::SEQ_W-1:0]         seq_r;
  logic [rwrb_pkg::SIZE_W-1:0]        size_r;
  logic                               ch_r;
  logic                               last_r;
  logic [rwrb_pkg::PCT_W-1:0]         rnd_r;
  logic [rwrb_pkg::SEQ_W-1:0]         dist_r;
  logic [PW-1:0]                      prod_r;
  logic [rwrb_pkg::SEQ_W-1:0]         start_r;
  logic [SLOTS-1:0]                   mask_r;
  logic                               flush_out_r;

  logic                               accept;
  logic                               is_drop;
  logic                               in_win;
  logic                               above;
  logic                               store;
  logic [IW-1:0]                      slot;
  logic [SLOTS-1:0]                   mask_new;
  logic                               prefix;
  logic                               flush;
  logic                               advance;
  rwrb_pkg::kind_t                    kind;

  assign in_tready = (state_r == F_IDLE) && !flush_out_r;
  assign accept    = in_tvalid && in_tready;

  assign is_drop  = !mode_r && (rnd_r < drop_percent);
  assign in_win   = (dist_r <= WIN_LAST);
  assign above    = !in_win && !dist_r[rwrb_pkg::SEQ_W-1];
  assign store    = !mode_r && !is_drop && in_win;
  assign slot     = prod_r[SH +: IW];
  assign mask_new = mask_r | (store ? (SLOTS'(1) << slot) : '0);
  // The filled slots form a prefix exactly when adding one clears all of them.
  assign prefix   = ((mask_new & (mask_new + SLOTS'(1))) == '0);
  assign flush    = mode_r ? prefix : (store && (last_r ? prefix : (&mask_new)));
  assign advance  = store && flush && !last_r;

  always_comb begin
    if (mode_r) begin
      kind = rwrb_pkg::KIND_DONE;
    end else if (is_drop) begin
      kind = rwrb_pkg::KIND_DROP;
    end else if (above) begin
      kind = rwrb_pkg::KIND_REJECT;
    end else begin
      kind = rwrb_pkg::KIND_ACK;
    end
  end

  assign q_push        = (state_r == F_DECIDE) && !q_full;
  assign q_job.kind    = kind;
  assign q_job.seq     = mode_r ? '0 : seq_r;
  assign q_job.channel = mode_r ? 1'b0 : ch_r;
  assign q_job.last    = (kind == rwrb_pkg::KIND_ACK) && last_r;
  assign q_job.flush   = flush;
  assign q_mask        = mask_new;

  assign ram_we           = q_push && store;
  assign ram_waddr        = slot;
  assign ram_wdata.offset = seq_r;
  assign ram_wdata.size   = size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      start_r     <= '0;
      mask_r      <= '0;
      flush_out_r <= 1'b0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            state_r <= F_CALC;
          end
        end
        F_CALC: begin
          state_r <= F_DECIDE;
        end
        F_DECIDE: begin
          if (q_push) begin
            state_r <= F_IDLE;
            mask_r  <= flush ? '0 : mask_new;
            if (advance) begin
              start_r <= start_r + WIN_SPAN;
            end
          end
        end
        default: state_r <= F_IDLE;
      endcase
      if (q_push && flush) begin
        flush_out_r <= 1'b1;
      end else if (flush_done) begin
        flush_out_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_tuser;
      seq_r  <= in_tdata[31:0];
      size_r <= in_tdata[40:32];
      ch_r   <= in_tdata[41];
      last_r <= in_tlast;
      rnd_r  <= in_tdata[48:42];
      dist_r <= in_tdata[31:0] - start_r;
    end
    if (state_r == F_CALC) begin
      prod_r <= PW'(dist_r[NB-1:0] * RECIP);
    end
  end

  // Only one flush may be in flight, since the slot store is read behind it.
  a_one_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && flush) |-> !flush_out_r)
    else $error("flush issued while another flush is outstanding");

  a_advance_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && advance) |=> (mask_r == '0))
    else $error("fill marks survived a window advance");

endmodule
`default_nettype wire

// ----- rtl/rwrb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rwrb_back
// Takes jobs from the queue, walks the slots of a flush through the slot
// store and drives the result channel from an output register.
// ----------------------------------------------------------------------------
module rwrb_back #(
  parameter int SLOTS = 8,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_empty,
  output logic                                   q_pop,
  input  wire rwrb_pkg::job_t                    q_job,
  input  wire logic [SLOTS-1:0]                  q_mask,
  output logic                                   ram_re,
  output logic      [IW-1:0]                     ram_raddr,
  input  wire rwrb_pkg::slot_t                   ram_rdata,
  output logic                                   flush_done,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [rwrb_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic      [2:0]                        out_tuser,
  output logic                                   out_tlast
);

  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_LOAD,
    B_FINAL
  } bstate_t;

  bstate_t                          state_r;
  rwrb_pkg::job_t                   job_r;
  logic [SLOTS-1:0]                 mask_r;
  logic [CW-1:0]                    idx_r;
  logic                             out_valid_r;
  rwrb_pkg::kind_t                  o_kind_r;
  logic [rwrb_pkg::SEQ_W-1:0]       o_seq_r;
  logic [rwrb_pkg::SIZE_W-1:0]      o_size_r;
  logic                             o_ch_r;
  logic                             o_last_r;
  logic [rwrb_pkg::SLOT_IDX_W-1:0]  o_slot_r;
  logic                             o_eor_r;

  logic                             out_free;
  logic                             scan_done;
  logic                             load_write;
  logic                             load_final;

  assign out_free   = !out_valid_r || out_tready;
  assign scan_done  = (idx_r == CW'(SLOTS));
  assign q_pop      = (state_r == B_IDLE) && !q_empty;
  assign ram_raddr  = idx_r[IW-1:0];
  assign ram_re     = (state_r == B_SCAN) && !scan_done && mask_r[idx_r[IW-1:0]];
  assign load_write = (state_r == B_LOAD) && out_free;
  assign load_final = (state_r == B_FINAL) && out_free;
  assign flush_done = load_final && job_r.flush;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_eor_r;
  assign out_tdata  = {2'b00, o_slot_r, o_last_r, o_ch_r, o_size_r, o_seq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_write || load_final) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            job_r   <= q_job;
            mask_r  <= q_mask;
            idx_r   <= '0;
            state_r <= q_job.flush ? B_SCAN : B_FINAL;
          end
        end
        B_SCAN: begin
          if (scan_done) begin
            state_r <= B_FINAL;
          end else if (ram_re) begin
            state_r <= B_LOAD;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        B_LOAD: begin
          if (out_free) begin
            o_kind_r <= rwrb_pkg::KIND_WRITE;
            o_seq_r  <= ram_rdata.offset;
            o_size_r <= ram_rdata.size;
            o_ch_r   <= 1'b0;
            o_last_r <= 1'b0;
            o_slot_r <= rwrb_pkg::SLOT_IDX_W'(idx_r);
            o_eor_r  <= 1'b0;
            idx_r    <= idx_r + CW'(1);
            state_r  <= B_SCAN;
          end
        end
        B_FINAL: begin
          if (out_free) begin
            o_kind_r <= job_r.kind;
            o_seq_r  <= job_r.seq;
            o_size_r <= '0;
            o_ch_r   <= job_r.channel;
            o_last_r <= job_r.last;
            o_slot_r <= '0;
            o_eor_r  <= 1'b1;
            state_r  <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // A write command is always followed by the closing word of its item.
  a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == rwrb_pkg::KIND_WRITE)) |-> !out_tlast)
    else $error("write command marked as end of run");

  a_load_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_LOAD) |-> job_r.flush)
    else $error("slot read outside a flush");

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the receive window reorder buffer. Input words go
// in as short file transfers with random content, out-of-order packets and
// retransmits. Stray packets below, inside and above the window, end words,
// and drop rates from zero to one hundred percent are mixed in. A scoreboard
// holds its own copy of the window and slots and checks every result word in
// order.
// ----------------------------------------------------------------------------
module tb;

  localparam int          NUM_SLOTS     = 8;
  localparam int          SLOT_SPAN     = 256;
  localparam logic [31:0] WIN_SPAN      = 32'(NUM_SLOTS * SLOT_SPAN);
  // A flush walks every slot, behind the classifier and the job queue; the
  // settle wait is set comfortably past the slowest word.
  localparam int          SETTLE_CYCLES = 40;
  localparam int          MAX_REPORTS   = 10;

  // Input word kinds carried on in_tuser.
  localparam bit MODE_DATA = 1'b0;
  localparam bit MODE_END  = 1'b1;

  // One result word, unpacked into its fields.
  typedef struct {
    rwrb_pkg::kind_t kind;
    logic [31:0]     seq;
    logic [8:0]      size;
    logic            channel;
    logic            last;
    logic [2:0]      slot;
    logic            end_of_run;
  } result_t;

  function automatic string describe(result_t r);
    return $sformatf("kind=%0d seq=%h size=%0d ch=%0b last=%0b slot=%0d eor=%0b",
                     r.kind, r.seq, r.size, r.channel, r.last, r.slot, r.end_of_run);
  endfunction

  // Scoreboard: tracks the receive window, the slot contents and the drop
  // rate, and keeps the result words still owed by the block in order.
  class window_scoreboard;
    bit          slot_filled[NUM_SLOTS];
    logic [31:0] slot_offset[NUM_SLOTS];
    logic [8:0]  slot_size[NUM_SLOTS];
    logic [31:0] win_start;
    logic [6:0]  drop_pct;
    result_t     owed_q[$];
    int          mismatches;

    function new();
      win_start  = '0;
      drop_pct   = '0;
      mismatches = 0;
      foreach (slot_filled[i]) slot_filled[i] = 1'b0;
    endfunction

    function void owe(rwrb_pkg::kind_t kind, logic [31:0] seq, logic [8:0] size,
                      logic channel, logic last, logic [2:0] slot, logic end_of_run);
      result_t r;
      r.kind = kind;
      r.seq = seq;
      r.size = size;
      r.channel = channel;
      r.last = last;
      r.slot = slot;
      r.end_of_run = end_of_run;
      owed_q.push_back(r);
    endfunction

    // Emits the filled slots as write commands when the buffer is full, or
    // when a final flush finds the filled slots packed at the front.
    function void flush_slots(bit final_flag);
      int count;
      bit gap;
      bit packed_front;
      count = 0;
      gap = 1'b0;
      packed_front = 1'b1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_filled[i]) begin
          count++;
          if (gap) packed_front = 1'b0;
        end else begin
          gap = 1'b1;
        end
      end
      if (count != NUM_SLOTS && !final_flag) return;
      if (final_flag && !packed_front) return;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_filled[i])
          owe(rwrb_pkg::KIND_WRITE, slot_offset[i], slot_size[i], 1'b0, 1'b0, 3'(i), 1'b0);
        slot_filled[i] = 1'b0;
      end
      if (!final_flag) win_start = win_start + WIN_SPAN;
    endfunction

    function void note_input(bit mode, logic [31:0] seq, logic [8:0] psize, logic channel,
                             logic last, logic [6:0] rnd);
      logic [31:0] delta;
      int slot;
      if (mode == MODE_END) begin
        flush_slots(1'b1);
        owe(rwrb_pkg::KIND_DONE, '0, '0, 1'b0, 1'b0, '0, 1'b1);
      end else if (rnd < drop_pct) begin
        owe(rwrb_pkg::KIND_DROP, seq, '0, channel, 1'b0, '0, 1'b1);
      end else begin
        delta = seq - win_start;
        if (delta < WIN_SPAN) begin
          slot = int'(delta / SLOT_SPAN);
          slot_filled[slot] = 1'b1;
          slot_offset[slot] = seq;
          slot_size[slot] = psize;
          flush_slots(last);
          owe(rwrb_pkg::KIND_ACK, seq, '0, channel, last, '0, 1'b1);
        end else if (!delta[31]) begin
          owe(rwrb_pkg::KIND_REJECT, seq, '0, channel, 1'b0, '0, 1'b1);
        end else begin
          owe(rwrb_pkg::KIND_ACK, seq, '0, channel, last, '0, 1'b1);
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: %s", describe(got));
        return;
      end
      want = owed_q.pop_front();
      if (got.kind !== want.kind || got.seq !== want.seq || got.size !== want.size ||
          got.channel !== want.channel || got.last !== want.last ||
          got.slot !== want.slot || got.end_of_run !== want.end_of_run) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result mismatch, expected: %s", describe(want));
          $display("                 actual:   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [rwrb_pkg::IN_DATA_W-1:0] in_tdata;    // seq_no, payload_size, channel, rand_value
  logic        in_tuser;                       // mode
  logic        in_tlast;                       // is_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // out_seq, out_size, out_channel, out_last, slot_index
  logic [rwrb_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [2:0]  out_tuser;                      // kind
  logic        out_tlast;                      // end_of_run
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [0:0]  cfg_paddr;
  logic [rwrb_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [rwrb_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic        cfg_pready;

  window_scoreboard sb;
  // While calm is set neither side inserts gaps.
  bit          calm;
  int          words_sent;

  receive_window_reorder_buffer_unit #(
    .SLOTS(NUM_SLOTS),
    .SLOT_BYTES(SLOT_SPAN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The result side stalls at random, about 13 percent of the time.
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 13);
  end

  // Every accepted result word is checked against the oldest one owed.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = rwrb_pkg::kind_t'(out_tuser);
      got.seq = out_tdata[31:0];
      got.size = out_tdata[40:32];
      got.channel = out_tdata[41];
      got.last = out_tdata[42];
      got.slot = out_tdata[45:43];
      got.end_of_run = out_tlast;
      sb.check_result(got);
    end
  end

  function automatic logic [8:0] pick_size();
    return ($urandom_range(0, 7) == 0) ? 9'd256 : 9'($urandom_range(0, 255));
  endfunction

  // Presents one input word after a random number of gap cycles and returns
  // right after the edge that took it. Valid is only lowered by a gap or by
  // wait_idle, so it never drops and rises within one time step.
  task automatic send_word(bit mode, logic [31:0] seq, logic [8:0] psize, logic channel,
                           logic last, logic [6:0] rnd);
    while (!calm && $urandom_range(0, 99) < 13) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tlast <= last;
    in_tdata <= {7'd0, rnd, channel, psize, seq};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(mode, seq, psize, channel, last, rnd);
    words_sent++;
  endtask

  // Lets the block drain: all owed words in, then the settle wait on top.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_drop(logic [6:0] pct);
    wait_idle();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= rwrb_pkg::REG_DROP_PERCENT;
    cfg_pwdata <= rwrb_pkg::CFG_DATA_W'(pct);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.drop_pct = pct;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // A stray word: mostly somewhere in or near the window, sometimes an end
  // word or a sequence number from anywhere.
  task automatic send_noise();
    int pick;
    logic [31:0] seq;
    pick = $urandom_range(0, 99);
    if (pick < 50) seq = sb.win_start + 32'($urandom_range(0, 2047));
    else if (pick < 65) seq = sb.win_start - 32'($urandom_range(1, 8192));
    else if (pick < 80) seq = sb.win_start + WIN_SPAN + 32'($urandom_range(0, 4095));
    else seq = $urandom;
    if ($urandom_range(0, 99) < 8)
      send_word(MODE_END, $urandom, pick_size(), 1'($urandom), 1'($urandom), 7'($urandom));
    else
      send_word(MODE_DATA, seq, pick_size(), 1'($urandom), $urandom_range(0, 99) < 10,
                7'($urandom_range(0, 99)));
  endtask

  // A well-formed burst: the sender fills the current window in shuffled
  // order with the odd retransmit and stray word, flags its final packet as
  // last when the burst is short, and usually follows with an end word.
  task automatic send_transfer();
    int count;
    int order[NUM_SLOTS];
    int j;
    int tmp;
    logic [31:0] base;
    bit mark_last;
    bit final_pkt;
    count = ($urandom_range(0, 2) == 0) ? $urandom_range(1, NUM_SLOTS - 1) : NUM_SLOTS;
    base = sb.win_start;
    for (int k = 0; k < NUM_SLOTS; k++) order[k] = k;
    for (int k = count - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    mark_last = (count < NUM_SLOTS) || ($urandom_range(0, 1) == 1);
    for (int k = 0; k < count; k++) begin
      final_pkt = (k == count - 1);
      if ($urandom_range(0, 9) == 0) send_noise();
      if (k > 0 && $urandom_range(0, 9) == 0)
        send_word(MODE_DATA, base + 32'(order[k-1] * SLOT_SPAN), 9'd256, 1'($urandom),
                  1'b0, 7'($urandom_range(0, 99)));
      send_word(MODE_DATA, base + 32'(order[k] * SLOT_SPAN), final_pkt ? pick_size() : 9'd256,
                1'($urandom), mark_last && final_pkt, 7'($urandom_range(0, 99)));
    end
    if ($urandom_range(0, 99) < 60)
      send_word(MODE_END, $urandom, pick_size(), 1'($urandom), 1'($urandom), 7'($urandom));
  endtask

  task automatic run_random(int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(0, 99) < 55) send_transfer();
      else send_noise();
    end
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    words_sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_DATA;
    in_tlast = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = rwrb_pkg::REG_DROP_PERCENT;
    cfg_pwdata = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, window starting at zero.
    write_drop(7'd0);
    send_word(MODE_DATA, 32'd0, 9'd256, 1'b1, 1'b0, 7'd99);        // first slot
    send_word(MODE_DATA, 32'd2047, 9'd0, 1'b0, 1'b0, 7'd0);        // last byte of window
    send_word(MODE_DATA, 32'hFFFF_FFFF, 9'd255, 1'b1, 1'b0, 7'd50); // just below window
    send_word(MODE_DATA, 32'd2048, 9'd17, 1'b1, 1'b0, 7'd3);       // just above window
    send_word(MODE_DATA, 32'h7FFF_FFFF, 9'd1, 1'b0, 1'b0, 7'd64);  // farthest ahead
    send_word(MODE_DATA, 32'h8000_0000, 9'd2, 1'b1, 1'b1, 7'd28);  // farthest behind
    send_word(MODE_DATA, 32'd5, 9'd100, 1'b0, 1'b0, 7'd10);        // overwrite first slot
    // A last packet with a hole in the filled slots must not flush, and an
    // end word in the same state only reports done.
    send_word(MODE_DATA, 32'd300, 9'd44, 1'b1, 1'b1, 7'd77);
    send_word(MODE_END, 32'd0, 9'd0, 1'b0, 1'b0, 7'd0);
    // Filling the remaining slots flushes all eight and moves the window.
    send_word(MODE_DATA, 32'd512, 9'd256, 1'b0, 1'b0, 7'd1);
    send_word(MODE_DATA, 32'd768, 9'd128, 1'b1, 1'b0, 7'd2);
    send_word(MODE_DATA, 32'd1024, 9'd511 & 9'd256, 1'b0, 1'b0, 7'd4);
    send_word(MODE_DATA, 32'd1280, 9'd255, 1'b1, 1'b0, 7'd8);
    send_word(MODE_DATA, 32'd1791, 9'd3, 1'b0, 1'b0, 7'd16);
    // A last packet into an empty window flushes only itself, no advance.
    send_word(MODE_DATA, 32'd2051, 9'd33, 1'b1, 1'b1, 7'd32);
    send_word(MODE_END, 32'hFFFF_FFFF, 9'd256, 1'b1, 1'b1, 7'd127);
    send_word(MODE_DATA, 32'd2304, 9'd200, 1'b0, 1'b0, 7'd60);
    send_word(MODE_DATA, 32'd2048, 9'd256, 1'b1, 1'b0, 7'd70);
    send_word(MODE_END, 32'd0, 9'd0, 1'b0, 1'b0, 7'd0);
    send_word(MODE_DATA, 32'd1000, 9'd10, 1'b1, 1'b1, 7'd90);      // stale retransmit

    // Everything dropped, but an end word is never dropped.
    write_drop(7'd100);
    send_word(MODE_DATA, 32'd2048, 9'd256, 1'b1, 1'b1, 7'd99);
    send_word(MODE_END, 32'd0, 9'd0, 1'b0, 1'b0, 7'd0);
    // Drop threshold at its edge.
    write_drop(7'd1);
    send_word(MODE_DATA, 32'd2560, 9'd9, 1'b0, 1'b0, 7'd0);
    send_word(MODE_DATA, 32'd3840, 9'd256, 1'b1, 1'b0, 7'd1);
    send_word(MODE_END, 32'd0, 9'd0, 1'b0, 1'b0, 7'd0);

    // Random part, several drop rates, one stretch with no gaps on either side.
    write_drop(7'd0);
    run_random(30);
    calm = 1'b1;
    run_random(40);
    calm = 1'b0;
    run_random(15);
    write_drop(7'd100);
    run_random(15);
    write_drop(7'($urandom_range(1, 99)));
    run_random(60);
    write_drop(7'($urandom_range(5, 40)));
    run_random(45);

    wait_idle();
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("receive_window_reorder_buffer_unit test passed");
    end else begin
      $display("receive_window_reorder_buffer_unit test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2400000;
    $display("receive_window_reorder_buffer_unit test failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rwrb_pkg.sv
rtl/rwrb_ram.sv
rtl/rwrb_queue.sv
rtl/rwrb_front.sv
rtl/rwrb_back.sv
rtl/receive_window_reorder_buffer_unit.sv
tb/sv/tb.sv
